@@ src/matrix_arith_unit_assert.svh @@
// Assertion macros for the matrix arithmetic unit.
`ifndef MATRIX_ARITH_UNIT_ASSERT_SVH
`define MATRIX_ARITH_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define MATU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MATU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/matu_pkg.sv @@
// Shared types and constants for the matrix arithmetic unit.
package matu_pkg;

  localparam int REQ_W      = 2;
  localparam int POS_W      = 3;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int DIM_CFG_W  = 4;
  localparam int FRAC_SHIFT = 8;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_TRN = 2'd3
  } op_mode_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_A = 2'd0,
    REQ_LOAD_B = 2'd1,
    REQ_START  = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OP_MODE    = 2'd0,
    CFG_ROW_COUNT  = 2'd1,
    CFG_COMMON_LEN = 2'd2,
    CFG_COL_COUNT  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } seq_state_t;

  typedef struct packed {
    logic             first;
    logic             last_k;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } elem_tag_t;

endpackage

@@ src/matrix_arith_unit.sv @@
// Top level of the matrix arithmetic unit: element stores, sequencer and MAC pipeline.
//
//  channel   handshake                 payload
//  -------   ------------------------  ----------------------------------------------
//  request   start / busy              req_type, row_index, col_index, elem_value
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//  result    out_strobe (one cycle)    out_row, out_col, out_value, saturated, last
//
//  A start issues one store read per cycle: common_len reads per element for multiply,
//  one per element otherwise, then the pipeline (RAM read, multiply, accumulate)
//  drains before the last result. Reset clears control state and restores config
//  defaults; store contents stay undefined until loaded.
//  The result side cannot stall; busy holds off requests until the last transaction.
module matrix_arith_unit #(
  parameter int MAX_DIM   = 8,
  parameter int ELEM_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [matu_pkg::REQ_W-1:0]        req_type,
  input  logic [matu_pkg::POS_W-1:0]        row_index,
  input  logic [matu_pkg::POS_W-1:0]        col_index,
  input  logic signed [ELEM_BITS-1:0]       elem_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [matu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [matu_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_strobe,
  output logic [matu_pkg::POS_W-1:0]        out_row,
  output logic [matu_pkg::POS_W-1:0]        out_col,
  output logic signed [matu_pkg::OUT_W-1:0] out_value,
  output logic                              saturated,
  output logic                              last
);

  import matu_pkg::*;

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int ACC_RAW = 2 * ELEM_BITS + $clog2(MAX_DIM) + 1;
  localparam int ACC_W   = (ACC_RAW > OUT_W) ? ACC_RAW : OUT_W + 1;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh8000_0000);

  op_mode_t             op_mode;
  logic [DIM_CFG_W-1:0] row_count;
  logic [DIM_CFG_W-1:0] common_len;
  logic [DIM_CFG_W-1:0] col_count;

  seq_state_t state;
  seq_state_t state_next;

  logic [IDX_W-1:0] outer_pos, outer_pos_next;
  logic [IDX_W-1:0] inner_pos, inner_pos_next;
  logic [IDX_W-1:0] k_pos, k_pos_next;

  logic [DIM_W-1:0] rows_dim, common_dim, cols_dim;
  logic [DIM_W-1:0] outer_lim, inner_lim, k_lim;
  logic             k_end, inner_end, outer_end;
  logic             issue;
  logic             req_accept;
  logic             load_in_range;
  logic             we_a, we_b;
  logic [AW-1:0]    load_addr;
  logic [AW-1:0]    a_raddr, b_raddr;
  logic signed [ELEM_BITS-1:0] a_rdata, b_rdata;
  logic signed [2*ELEM_BITS-1:0] prod;

  logic      s1_valid;
  elem_tag_t s1_tag;
  elem_tag_t issue_tag;
  logic      s2_valid;
  elem_tag_t s2_tag;
  logic signed [ACC_W-1:0] s2_term;
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] acc_next;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] d);
    logic [DIM_W-1:0] res;
    if (d == '0) begin
      res = DIM_W'(1);
    end else if (32'(d) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(d);
    end
    return res;
  endfunction

  assign cfg_ready  = !busy;
  assign req_accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode    <= OP_MUL;
      row_count  <= DIM_CFG_W'(8);
      common_len <= DIM_CFG_W'(8);
      col_count  <= DIM_CFG_W'(8);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_OP_MODE:    op_mode    <= op_mode_t'(cfg_data[1:0]);
        CFG_ROW_COUNT:  row_count  <= cfg_data;
        CFG_COMMON_LEN: common_len <= cfg_data;
        CFG_COL_COUNT:  col_count  <= cfg_data;
      endcase
    end
  end

  assign load_in_range = (32'(row_index) < MAX_DIM) && (32'(col_index) < MAX_DIM);
  assign load_addr     = AW'(row_index) * AW'(MAX_DIM) + AW'(col_index);
  assign we_a = req_accept && load_in_range && (req_type == REQ_LOAD_A);
  assign we_b = req_accept && load_in_range && (req_type == REQ_LOAD_B);

  assign rows_dim   = clamp_dim(row_count);
  assign common_dim = clamp_dim(common_len);
  assign cols_dim   = clamp_dim(col_count);
  assign outer_lim  = (op_mode == OP_TRN) ? cols_dim : rows_dim;
  assign inner_lim  = (op_mode == OP_TRN) ? rows_dim : cols_dim;
  assign k_lim      = (op_mode == OP_MUL) ? common_dim : DIM_W'(1);

  assign k_end     = (DIM_W'(k_pos) == k_lim - DIM_W'(1));
  assign inner_end = (DIM_W'(inner_pos) == inner_lim - DIM_W'(1));
  assign outer_end = (DIM_W'(outer_pos) == outer_lim - DIM_W'(1));

  always_comb begin
    unique case (op_mode)
      OP_MUL: begin
        a_raddr = AW'(outer_pos) * AW'(MAX_DIM) + AW'(k_pos);
        b_raddr = AW'(k_pos) * AW'(MAX_DIM) + AW'(inner_pos);
      end
      OP_ADD, OP_SUB: begin
        a_raddr = AW'(outer_pos) * AW'(MAX_DIM) + AW'(inner_pos);
        b_raddr = a_raddr;
      end
      OP_TRN: begin
        a_raddr = AW'(inner_pos) * AW'(MAX_DIM) + AW'(outer_pos);
        b_raddr = a_raddr;
      end
    endcase
  end

  matu_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_a_store (
    .clk   (clk),
    .we    (we_a),
    .waddr (load_addr),
    .wdata (elem_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  matu_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_b_store (
    .clk   (clk),
    .we    (we_b),
    .waddr (load_addr),
    .wdata (elem_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  always_comb begin
    state_next     = state;
    outer_pos_next = outer_pos;
    inner_pos_next = inner_pos;
    k_pos_next     = k_pos;
    issue          = 1'b0;
    busy           = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start && req_type == REQ_START) begin
          state_next     = ST_ISSUE;
          outer_pos_next = '0;
          inner_pos_next = '0;
          k_pos_next     = '0;
        end
      end
      ST_ISSUE: begin
        issue = 1'b1;
        if (!k_end) begin
          k_pos_next = k_pos + IDX_W'(1);
        end else begin
          k_pos_next = '0;
          if (!inner_end) begin
            inner_pos_next = inner_pos + IDX_W'(1);
          end else begin
            inner_pos_next = '0;
            if (!outer_end) begin
              outer_pos_next = outer_pos + IDX_W'(1);
            end else begin
              state_next = ST_DRAIN;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (s2_valid && s2_tag.last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      outer_pos <= '0;
      inner_pos <= '0;
      k_pos     <= '0;
    end else begin
      state     <= state_next;
      outer_pos <= outer_pos_next;
      inner_pos <= inner_pos_next;
      k_pos     <= k_pos_next;
    end
  end

  always_comb begin
    issue_tag.first  = (k_pos == '0);
    issue_tag.last_k = k_end;
    issue_tag.last   = k_end && inner_end && outer_end;
    issue_tag.row    = POS_W'(outer_pos);
    issue_tag.col    = POS_W'(inner_pos);
  end

  assign prod = a_rdata * b_rdata;

  always_comb begin
    unique case (op_mode)
      OP_MUL: term = ACC_W'(prod);
      OP_ADD: term = (ACC_W'(a_rdata) + ACC_W'(b_rdata)) <<< FRAC_SHIFT;
      OP_SUB: term = (ACC_W'(a_rdata) - ACC_W'(b_rdata)) <<< FRAC_SHIFT;
      OP_TRN: term = ACC_W'(a_rdata) <<< FRAC_SHIFT;
    endcase
  end

  assign acc_next = (s2_tag.first ? ACC_W'(0) : acc) + s2_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      s1_valid   <= issue;
      s2_valid   <= s1_valid;
      out_strobe <= s2_valid && s2_tag.last_k;
    end
  end

  always_ff @(posedge clk) begin
    s1_tag  <= issue_tag;
    s2_tag  <= s1_tag;
    s2_term <= term;
    if (s2_valid) begin
      acc <= acc_next;
    end
    if (s2_valid && s2_tag.last_k) begin
      out_row <= s2_tag.row;
      out_col <= s2_tag.col;
      last    <= s2_tag.last;
      if (acc_next > SAT_HI) begin
        out_value <= OUT_W'(SAT_HI);
        saturated <= 1'b1;
      end else if (acc_next < SAT_LO) begin
        out_value <= OUT_W'(SAT_LO);
        saturated <= 1'b1;
      end else begin
        out_value <= OUT_W'(acc_next);
        saturated <= 1'b0;
      end
    end
  end

`include "matrix_arith_unit_assert.svh"

  `MATU_ASSERT_NEXT(a_start_busy, start && !busy && req_type == REQ_START, busy, "start not taken")
  `MATU_ASSERT_NOW(a_last_idle, out_strobe && last, !busy, "busy after last result")
  `MATU_ASSERT_NOW(a_strobe_busy, out_strobe, $past(busy), "result without compute")
  `MATU_ASSERT_NOW(a_sat_value, out_strobe && saturated, out_value == 32'sh7FFF_FFFF || out_value == -32'sh8000_0000, "bad clip value")

endmodule

@@ src/matu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module matu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
